@@ rtl/lcri_pkg.sv @@
// shared types and constants for the ldpc constraint row index pipeline
package lcri_pkg;

    localparam int COL_W     = 13;
    localparam int ROW_W     = 10;
    localparam int DIV_STEPS = COL_W;
    localparam int ADD_STEPS = 2;

    localparam logic [ROW_W-1:0] MIN_ROWS = ROW_W'(2);

    typedef struct packed {
        logic             last;
        logic [COL_W-1:0] num;
        logic [ROW_W-1:0] rem;
        logic [COL_W-1:0] quo;
        logic [ROW_W-1:0] row0;
    } div_tok_t;

    typedef struct packed {
        logic             last;
        logic [ROW_W-1:0] step;
        logic [ROW_W-1:0] row0;
        logic [ROW_W-1:0] row1;
        logic [ROW_W-1:0] row2;
    } add_tok_t;

endpackage

@@ rtl/lcri_div_cell.sv @@
// one restoring division step: shifts in a dividend bit and yields one quotient bit
module lcri_div_cell
    import lcri_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [ROW_W-1:0] div,
    input  logic             valid_in,
    input  div_tok_t         tok_in,
    output logic             valid_out,
    output div_tok_t         tok_out
);

    logic             valid_reg;
    div_tok_t         tok_reg;
    div_tok_t         tok_next;
    logic [ROW_W:0]   trial;
    logic [ROW_W:0]   diff;
    logic             ge;

    assign trial = {tok_in.rem, tok_in.num[COL_W-1]};
    assign diff  = trial - {1'b0, div};
    assign ge    = (trial >= {1'b0, div});

    always_comb
    begin
        tok_next      = tok_in;
        tok_next.num  = {tok_in.num[COL_W-2:0], 1'b0};
        tok_next.quo  = {tok_in.quo[COL_W-2:0], ge};
        tok_next.rem  = ge ? diff[ROW_W-1:0] : trial[ROW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign valid_out = valid_reg;
    assign tok_out   = tok_reg;

endmodule

@@ rtl/lcri_add_cell.sv @@
// one modular step: adds the step to the newest row modulo s and shifts the row list
module lcri_add_cell
    import lcri_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [ROW_W-1:0] modulus,
    input  logic             valid_in,
    input  add_tok_t         tok_in,
    output logic             valid_out,
    output add_tok_t         tok_out
);

    logic             valid_reg;
    add_tok_t         tok_reg;
    add_tok_t         tok_next;
    logic [ROW_W:0]   sum;
    logic [ROW_W:0]   wrapped;

    assign sum     = {1'b0, tok_in.row2} + {1'b0, tok_in.step};
    assign wrapped = sum - {1'b0, modulus};

    always_comb
    begin
        tok_next      = tok_in;
        tok_next.row0 = tok_in.row1;
        tok_next.row1 = tok_in.row2;
        tok_next.row2 = (sum >= {1'b0, modulus}) ? wrapped[ROW_W-1:0] : sum[ROW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign valid_out = valid_reg;
    assign tok_out   = tok_reg;

endmodule

@@ rtl/ldpc_constraint_row_indices.sv @@
// top level: raptor10 ldpc constraint row indices for a stream of source column indices
// Takes one column index per cycle, unless the output is held, and returns the three LDPC
// rows set in that column. 13 division cells find i / S and i mod S, 13 more find the
// quotient mod (S - 1), and two modular add cells form the second and third rows, the last
// of them being the output register. Throughput is one transfer per cycle; when the output
// is held the whole row of cells stalls. The user must write the row count register only
// while no transfer is in flight; the block does not enforce this. Values below 2 act as 2.
module ldpc_constraint_row_indices
    import lcri_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ldpc_rows_we,
    input  logic [ROW_W-1:0] ldpc_rows_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // column_index [12:0]
    input  logic             s_tlast,   // last_column
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // row_first [9:0], row_second [19:10], row_third [29:20]
    output logic             m_tlast    // end_of_columns
);

    logic [ROW_W-1:0] ldpc_rows_reg;
    logic [ROW_W-1:0] s_eff;
    logic [ROW_W-1:0] s_minus1;
    logic             en;

    logic             q_valid [0:DIV_STEPS];
    div_tok_t         q_tok   [0:DIV_STEPS];
    logic             m_valid [0:DIV_STEPS];
    div_tok_t         m_tok   [0:DIV_STEPS];
    logic             a_valid [0:ADD_STEPS];
    add_tok_t         a_tok   [0:ADD_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ldpc_rows_reg <= MIN_ROWS;
        end
        else if (ldpc_rows_we)
        begin
            ldpc_rows_reg <= ldpc_rows_wdata;
        end
    end

    assign s_eff    = (ldpc_rows_reg < MIN_ROWS) ? MIN_ROWS : ldpc_rows_reg;
    assign s_minus1 = s_eff - ROW_W'(1);

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // quotient and remainder of i by s
    assign q_valid[0] = s_tvalid;
    assign q_tok[0]   = '{last: s_tlast, num: s_tdata[COL_W-1:0], rem: '0, quo: '0,
                          row0: '0};

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_quo
        lcri_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .div       (s_eff),
            .valid_in  (q_valid[k]),
            .tok_in    (q_tok[k]),
            .valid_out (q_valid[k+1]),
            .tok_out   (q_tok[k+1])
        );
    end

    // quotient mod (s - 1)
    assign m_valid[0] = q_valid[DIV_STEPS];
    assign m_tok[0]   = '{last: q_tok[DIV_STEPS].last, num: q_tok[DIV_STEPS].quo, rem: '0,
                          quo: '0, row0: q_tok[DIV_STEPS].rem};

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_mod
        lcri_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .div       (s_minus1),
            .valid_in  (m_valid[k]),
            .tok_in    (m_tok[k]),
            .valid_out (m_valid[k+1]),
            .tok_out   (m_tok[k+1])
        );
    end

    // second and third rows
    assign a_valid[0] = m_valid[DIV_STEPS];
    assign a_tok[0]   = '{last: m_tok[DIV_STEPS].last,
                          step: m_tok[DIV_STEPS].rem + ROW_W'(1),
                          row0: m_tok[DIV_STEPS].row0,
                          row1: m_tok[DIV_STEPS].row0,
                          row2: m_tok[DIV_STEPS].row0};

    for (genvar k = 0; k < ADD_STEPS; k++)
    begin : g_add
        lcri_add_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .modulus   (s_eff),
            .valid_in  (a_valid[k]),
            .tok_in    (a_tok[k]),
            .valid_out (a_valid[k+1]),
            .tok_out   (a_tok[k+1])
        );
    end

    assign m_tvalid = a_valid[ADD_STEPS];
    assign m_tlast  = a_tok[ADD_STEPS].last;
    assign m_tdata  = {2'b00, a_tok[ADD_STEPS].row2, a_tok[ADD_STEPS].row1,
                       a_tok[ADD_STEPS].row0};

    a_rows_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:0] < s_eff) && (m_tdata[19:10] < s_eff)
                     && (m_tdata[29:20] < s_eff))
        else $error("row index not below row count");

    a_accept_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> q_valid[1])
        else $error("accepted transfer missing from first cell");

    a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(q_valid[1]) && $stable(m_valid[1]) && $stable(a_valid[1]))
        else $error("cells moved while output stalled");

endmodule
